[hw/rtl/lru_rt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lru_rt_pkg
// shared sizes, codes and controller types of the lru replacement tracker
// ----------------------------------------------------------------------------
package lru_rt_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_BITS    = 32;
	localparam int PAGE_W      = 32;
	localparam int CAP_W       = 5;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int RANK_W      = IDX_W;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_TOUCH  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic commit;
	} dp_cmd_t;

endpackage
`default_nettype wire

[hw/rtl/lru_rt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lru_rt_ctrl
// sequencer: accept a word, compare cycle, update cycle, result handshake
// ----------------------------------------------------------------------------
module lru_rt_ctrl (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                logic out_ready,
	output lru_rt_pkg::dp_cmd_t cmd
);

	lru_rt_pkg::state_t state_q;
	lru_rt_pkg::state_t state_d;
	logic               out_valid_q;
	logic               commit;

	always_comb begin
		state_d = state_q;
		case (state_q)
			lru_rt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lru_rt_pkg::ST_LOOKUP;
				end
			end
			lru_rt_pkg::ST_LOOKUP: begin
				state_d = lru_rt_pkg::ST_UPDATE;
			end
			lru_rt_pkg::ST_UPDATE: begin
				if (commit) begin
					state_d = lru_rt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lru_rt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		commit     = 1'b0;
		cmd.lookup = 1'b0;
		case (state_q)
			lru_rt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			lru_rt_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			lru_rt_pkg::ST_UPDATE: begin
				commit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.load   = in_valid && in_ready;
		cmd.commit = commit;
		out_valid  = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lru_rt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/lru_rt_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lru_rt_dp
// key slots with recency ranks, parallel key compare, victim and free slot
// selection, rank update and result register
// ----------------------------------------------------------------------------
module lru_rt_dp (
	input  wire                 logic clk,
	input  wire                 logic arst_n,
	input  wire                 lru_rt_pkg::dp_cmd_t cmd,
	input  wire                 logic cfg_we,
	input  wire                 logic [lru_rt_pkg::CAP_W-1:0] cfg_wdata,
	input  wire                 logic req_type,
	input  wire                 logic [lru_rt_pkg::PAGE_W-1:0] page_key,
	output logic                found,
	output logic                evicted,
	output logic [lru_rt_pkg::PAGE_W-1:0] evicted_key
);

	logic [lru_rt_pkg::CAP_W-1:0]    capacity_q;
	logic                            req_q;
	logic [lru_rt_pkg::KEY_BITS-1:0] key_q;

	logic [lru_rt_pkg::KEY_BITS-1:0] key_store_q [lru_rt_pkg::MAX_ENTRIES];
	logic [lru_rt_pkg::MAX_ENTRIES-1:0] valid_q;
	logic [lru_rt_pkg::RANK_W-1:0]   rank_q [lru_rt_pkg::MAX_ENTRIES];
	logic [lru_rt_pkg::CNT_W-1:0]    count_q;

	logic                            hit_q;
	logic                            evict_q;
	logic [lru_rt_pkg::IDX_W-1:0]    hit_idx_q;
	logic [lru_rt_pkg::IDX_W-1:0]    victim_idx_q;
	logic [lru_rt_pkg::IDX_W-1:0]    free_idx_q;

	logic                            found_q;
	logic                            evicted_q;
	logic [lru_rt_pkg::PAGE_W-1:0]   evicted_key_q;

	logic [lru_rt_pkg::MAX_ENTRIES-1:0] match;
	logic [lru_rt_pkg::MAX_ENTRIES-1:0] avail_mask;
	logic                            hit;
	logic                            evict;
	logic [lru_rt_pkg::IDX_W-1:0]    hit_idx;
	logic [lru_rt_pkg::IDX_W-1:0]    victim_idx;
	logic [lru_rt_pkg::IDX_W-1:0]    free_idx;
	logic [lru_rt_pkg::CMP_W-1:0]    cap_ext;
	logic [lru_rt_pkg::CMP_W-1:0]    eff_cap;
	logic [lru_rt_pkg::CNT_W-1:0]    lru_rank;
	logic                            do_insert;

	// compare cycle
	always_comb begin
		for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_store_q[i] == key_q);
		end
		hit     = |match;
		hit_idx = '0;
		for (int i = lru_rt_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = lru_rt_pkg::IDX_W'(i);
			end
		end

		cap_ext = lru_rt_pkg::CMP_W'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = lru_rt_pkg::CMP_W'(1);
		end else if (cap_ext > lru_rt_pkg::CMP_W'(lru_rt_pkg::MAX_ENTRIES)) begin
			eff_cap = lru_rt_pkg::CMP_W'(lru_rt_pkg::MAX_ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		evict = !hit && (req_q == lru_rt_pkg::REQ_INSERT)
			&& (lru_rt_pkg::CMP_W'(count_q) >= eff_cap);

		// oldest valid slot holds rank count-1
		lru_rank   = count_q - lru_rt_pkg::CNT_W'(1);
		victim_idx = '0;
		for (int i = lru_rt_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && (lru_rt_pkg::CNT_W'(rank_q[i]) == lru_rank)) begin
				victim_idx = lru_rt_pkg::IDX_W'(i);
			end
		end

		avail_mask = ~valid_q;
		if (evict) begin
			avail_mask[victim_idx] = 1'b1;
		end
		free_idx = '0;
		for (int i = lru_rt_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
			if (avail_mask[i]) begin
				free_idx = lru_rt_pkg::IDX_W'(i);
			end
		end
	end

	assign do_insert = !hit_q && (req_q == lru_rt_pkg::REQ_INSERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lru_rt_pkg::CAP_RESET;
			valid_q    <= '0;
			count_q    <= '0;
			for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				if (hit_q) begin
					for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++) begin
						if (valid_q[i] && (rank_q[i] < rank_q[hit_idx_q])) begin
							rank_q[i] <= rank_q[i] + lru_rt_pkg::RANK_W'(1);
						end
					end
					rank_q[hit_idx_q] <= '0;
				end else if (do_insert) begin
					for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++) begin
						if (valid_q[i]
							&& !(evict_q && (victim_idx_q == lru_rt_pkg::IDX_W'(i)))) begin
							rank_q[i] <= rank_q[i] + lru_rt_pkg::RANK_W'(1);
						end
					end
					if (evict_q) begin
						valid_q[victim_idx_q] <= 1'b0;
						rank_q[victim_idx_q]  <= '0;
						count_q               <= count_q;
					end else begin
						count_q <= count_q + lru_rt_pkg::CNT_W'(1);
					end
					valid_q[free_idx_q] <= 1'b1;
					rank_q[free_idx_q]  <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= lru_rt_pkg::KEY_BITS'(page_key);
		end
		if (cmd.lookup) begin
			hit_q        <= hit;
			hit_idx_q    <= hit_idx;
			evict_q      <= evict;
			victim_idx_q <= victim_idx;
			free_idx_q   <= free_idx;
		end
		if (cmd.commit) begin
			found_q   <= hit_q;
			evicted_q <= evict_q;
			if (evict_q) begin
				evicted_key_q <= lru_rt_pkg::PAGE_W'(key_store_q[victim_idx_q]);
			end else begin
				evicted_key_q <= '0;
			end
			if (do_insert) begin
				key_store_q[free_idx_q] <= key_q;
			end
		end
	end

	assign found       = found_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule
`default_nettype wire

[hw/rtl/lru_replacement_tracker_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lru_replacement_tracker_core
// least recently used replacement list of page keys
// ----------------------------------------------------------------------------
// Each word passes three steps: the acceptance edge, a compare state in which
// all slots compare the key in parallel and the victim and free slots are
// picked, and an update state that shifts the recency ranks and loads the
// result register. The sequencer handles one word at a time; a word is
// accepted while the previous result still waits, and its update state holds
// until that result is taken. The user must write capacity through cfg_we /
// cfg_wdata only while idle; the block itself does not enforce this. Lowering
// it below the current count drops keys only on later inserts.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_core (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic cfg_we,
	input  wire  logic [lru_rt_pkg::CAP_W-1:0] cfg_wdata,
	input  wire  logic in_valid,
	output logic in_ready,
	input  wire  logic req_type,
	input  wire  logic [lru_rt_pkg::PAGE_W-1:0] page_key,
	output logic out_valid,
	input  wire  logic out_ready,
	output logic found,
	output logic evicted,
	output logic [lru_rt_pkg::PAGE_W-1:0] evicted_key
);

	lru_rt_pkg::dp_cmd_t cmd;

	lru_rt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	lru_rt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_type    (req_type),
		.page_key    (page_key),
		.found       (found),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the lru replacement tracker against a scoreboard model of its list
// ----------------------------------------------------------------------------
// A table of directed words and capacity writes runs first. It covers a touch
// miss after reset, inserts of the extreme keys, an insert hit, and capacity
// 1, 0 and lowered below the current count. Then random phases follow, one
// per capacity setting: most keys come from a small pool so that hits and
// evictions are frequent. Random valid and ready gaps are used on both sides,
// with one phase that has no gaps. Every result is compared field by field
// with the table's expected values for typed rows, else with the scoreboard model.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 100000;

	typedef struct packed {
		logic found;
		logic evicted;
		logic [lru_rt_pkg::PAGE_W-1:0] evicted_key;
	} lru_result_t;

	typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic req;
		logic [lru_rt_pkg::PAGE_W-1:0] value;
		logic typed;
		lru_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lru_rt_pkg::CAP_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = lru_rt_pkg::REQ_INSERT;
	logic [lru_rt_pkg::PAGE_W-1:0] page_key = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic found;
	logic evicted;
	logic [lru_rt_pkg::PAGE_W-1:0] evicted_key;

	logic cur_typed = 1'b0;
	lru_result_t cur_want = '0;
	bit quiet = 1'b0;

	logic [lru_rt_pkg::PAGE_W-1:0] lru_keys [lru_rt_pkg::MAX_ENTRIES];
	bit lru_live [lru_rt_pkg::MAX_ENTRIES] = '{default: 1'b0};
	int lru_rank [lru_rt_pkg::MAX_ENTRIES] = '{default: 0};
	int lru_count = 0;
	logic [lru_rt_pkg::CAP_W-1:0] lru_cap = lru_rt_pkg::CAP_RESET;

	lru_result_t pending_results [$];
	int errors = 0;
	int words_in = 0;
	int results_out = 0;
	int lru_hits = 0;
	int lru_evictions = 0;
	int cap_writes = 0;
	int cycles = 0;

	stim_row_t dir_rows [20] = '{
		'{ROW_WORD, lru_rt_pkg::REQ_TOUCH,  32'h12345678, 1'b1, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h00000000, 1'b1, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h00000000, 1'b1, '{1'b1, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_TOUCH,  32'hFFFFFFFF, 1'b1, '{1'b1, 1'b0, 32'h00000000}},
		// capacity 1 while two keys are held
		'{ROW_CAP,  lru_rt_pkg::REQ_INSERT, 32'd1,        1'b0, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'hA5A5A5A5, 1'b1, '{1'b0, 1'b1, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h5A5A5A5A, 1'b1, '{1'b0, 1'b1, 32'hFFFFFFFF}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h00000001, 1'b1, '{1'b0, 1'b1, 32'hA5A5A5A5}},
		// capacity 0 acts as 1
		'{ROW_CAP,  lru_rt_pkg::REQ_INSERT, 32'd0,        1'b0, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h80000000, 1'b1, '{1'b0, 1'b1, 32'h5A5A5A5A}},
		'{ROW_WORD, lru_rt_pkg::REQ_TOUCH,  32'h00000001, 1'b1, '{1'b1, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h7FFFFFFF, 1'b1, '{1'b0, 1'b1, 32'h80000000}},
		'{ROW_CAP,  lru_rt_pkg::REQ_INSERT, 32'd4,        1'b0, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'hDEADBEEF, 1'b0, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h0BADF00D, 1'b0, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h13572468, 1'b0, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_TOUCH,  32'h00000001, 1'b0, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_INSERT, 32'h2468ACE0, 1'b0, '{1'b0, 1'b0, 32'h00000000}},
		'{ROW_WORD, lru_rt_pkg::REQ_TOUCH,  32'h2468ACE0, 1'b0, '{1'b0, 1'b0, 32'h00000000}}
	};

	logic [lru_rt_pkg::CAP_W-1:0] phase_caps [10] = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31,
		5'd17, 5'd3, 5'd8, 5'd15, 5'd16};

	lru_replacement_tracker_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.page_key    (page_key),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(input string what,
		input logic [lru_rt_pkg::PAGE_W-1:0] got,
		input logic [lru_rt_pkg::PAGE_W-1:0] want);
		$display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
		errors++;
	endtask

	task automatic predict_lru(input logic t, input logic [lru_rt_pkg::PAGE_W-1:0] k,
		output lru_result_t r);
		int hit;
		int victim;
		int eff;
		int top;
		bit placed;
		hit = -1;
		victim = -1;
		placed = 1'b0;
		r = '0;
		for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++)
			if (hit < 0 && lru_live[i] && lru_keys[i] == k)
				hit = i;
		if (hit >= 0) begin
			top = lru_rank[hit];
			for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++)
				if (lru_live[i] && lru_rank[i] < top)
					lru_rank[i]++;
			lru_rank[hit] = 0;
			r.found = 1'b1;
			lru_hits++;
		end else if (t == lru_rt_pkg::REQ_INSERT) begin
			eff = (lru_cap == 0) ? 1
				: (lru_cap > lru_rt_pkg::MAX_ENTRIES) ? lru_rt_pkg::MAX_ENTRIES
				: int'(lru_cap);
			if (lru_count >= eff) begin
				for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++)
					if (lru_live[i] && (victim < 0 || lru_rank[i] > lru_rank[victim]))
						victim = i;
				if (victim >= 0) begin
					r.evicted = 1'b1;
					r.evicted_key = lru_keys[victim];
					lru_live[victim] = 1'b0;
					lru_rank[victim] = 0;
					lru_count--;
					lru_evictions++;
				end
			end
			for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++)
				if (lru_live[i])
					lru_rank[i]++;
			for (int i = 0; i < lru_rt_pkg::MAX_ENTRIES; i++)
				if (!placed && !lru_live[i]) begin
					lru_live[i] = 1'b1;
					lru_keys[i] = k;
					lru_rank[i] = 0;
					lru_count++;
					placed = 1'b1;
				end
		end
	endtask

	always @(posedge clk) begin
		lru_result_t want;
		lru_result_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_lru(req_type, page_key, want);
				if (cur_typed)
					want = cur_want;
				pending_results.push_back(want);
				words_in++;
			end
			if (out_valid === 1'b1 && out_ready) begin
				got = '{found, evicted, evicted_key};
				results_out++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected word", got.evicted_key, '0);
				end else begin
					want = pending_results.pop_front();
					if (got.found !== want.found)
						report_mismatch("found", lru_rt_pkg::PAGE_W'(got.found),
							lru_rt_pkg::PAGE_W'(want.found));
					if (got.evicted !== want.evicted)
						report_mismatch("evicted", lru_rt_pkg::PAGE_W'(got.evicted),
							lru_rt_pkg::PAGE_W'(want.evicted));
					if (got.evicted_key !== want.evicted_key)
						report_mismatch("evicted_key", got.evicted_key, want.evicted_key);
				end
			end
		end
	end

	always @(negedge clk)
		out_ready <= quiet || $urandom_range(99) >= 24;

	task automatic send_word(input logic t, input logic [lru_rt_pkg::PAGE_W-1:0] k,
		input logic typed, input lru_result_t w);
		while (!quiet && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= t;
		page_key <= k;
		cur_typed <= typed;
		cur_want <= w;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [lru_rt_pkg::CAP_W-1:0] v);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		lru_cap = v;
		cap_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		stim_row_t row;
		lru_result_t none;
		logic [lru_rt_pkg::PAGE_W-1:0] pool [20];
		logic [lru_rt_pkg::PAGE_W-1:0] k;
		logic t;
		int span;
		none = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			if (row.kind == ROW_CAP)
				write_capacity(row.value[lru_rt_pkg::CAP_W-1:0]);
			else
				send_word(row.req, row.value, row.typed, row.want);
		end

		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			quiet = (p == 4);
			// odd pool entries differ from their neighbor in one bit
			for (int i = 0; i < 20; i++)
				pool[i] = (i % 2 == 0) ? $urandom : pool[i-1] ^ (32'h1 << $urandom_range(31));
			span = ((phase_caps[p] > lru_rt_pkg::MAX_ENTRIES) ? lru_rt_pkg::MAX_ENTRIES
				: int'(phase_caps[p])) + 4;
			repeat (90) begin
				t = ($urandom_range(99) < 60) ? lru_rt_pkg::REQ_INSERT : lru_rt_pkg::REQ_TOUCH;
				k = ($urandom_range(99) < 85) ? pool[$urandom_range(span - 1)] : $urandom;
				send_word(t, k, 1'b0, none);
			end
		end
		quiet = 1'b0;
		wait_for_results();

		$display("run: %0d words in, %0d words out, %0d capacity writes", words_in,
			results_out, cap_writes);
		$display("run: %0d hits, %0d evictions, %0d mismatches", lru_hits, lru_evictions,
			errors);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

[lru_replacement_tracker_core.f]
hw/rtl/lru_rt_pkg.sv
hw/rtl/lru_rt_ctrl.sv
hw/rtl/lru_rt_dp.sv
hw/rtl/lru_replacement_tracker_core.sv
verif/tb.sv
